@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is applied
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tram_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tram_pkg;

	localparam int X_BYTE_POS       = 2;
	localparam int Y_BYTE_POS       = 4;
	localparam int PEN_TAG          = 2;
	localparam int MAX_REPORT_BYTES = 64;

	localparam int ALT_PEN_TAG     = 16;
	localparam int MIN_SHIFTED_LEN = 6;
	localparam int CAP_SLOTS       = 6;

	localparam int IDX_W = $clog2(MAX_REPORT_BYTES + 1);

	typedef enum logic [2:0] {
		REG_LIMIT_X = 3'd0,
		REG_LIMIT_Y = 3'd1,
		REG_GAIN_XX = 3'd2,
		REG_GAIN_XY = 3'd3,
		REG_GAIN_YX = 3'd4,
		REG_GAIN_YY = 3'd5,
		REG_BIAS_X  = 3'd6,
		REG_BIAS_Y  = 3'd7
	} cfg_reg_t;

	// raw point as extracted on the last byte of a report
	typedef struct packed {
		logic        keep;
		logic [15:0] rx;
		logic [15:0] ry;
	} point_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

	// byte position held by capture slot j: three around X, then three around Y
	function automatic logic [IDX_W-1:0] slot_pos(input int j);
		int p;
		p = (j < 3) ? (X_BYTE_POS - 1 + j) : (Y_BYTE_POS - 1 + j - 3);
		return IDX_W'(p);
	endfunction

endpackage

`default_nettype wire

@@ rtl/tram_capture.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tram_capture (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [7:0]           report_byte,
	input  wire logic                 last_byte,
	input  wire logic [15:0]          limit_x,
	input  wire logic [15:0]          limit_y,
	output tram_pkg::point_t          pt
);

	logic [tram_pkg::IDX_W-1:0] idx_q;
	logic [tram_pkg::IDX_W-1:0] cnt_d;
	logic [7:0]                 lead_q;
	logic [7:0]                 lead_d;
	logic [7:0]                 cap_q [tram_pkg::CAP_SLOTS];
	logic [7:0]                 cap_d [tram_pkg::CAP_SLOTS];
	logic                       live;
	logic                       id_ok;
	logic [15:0]                rx;
	logic [15:0]                ry;

	assign live = idx_q < tram_pkg::IDX_W'(tram_pkg::MAX_REPORT_BYTES);

	// view of the report with the current byte already stored
	always_comb begin
		for (int j = 0; j < tram_pkg::CAP_SLOTS; j++) begin
			cap_d[j] = (live && idx_q == tram_pkg::slot_pos(j)) ? report_byte : cap_q[j];
		end
		lead_d = (live && idx_q == '0) ? report_byte : lead_q;
		cnt_d  = live ? idx_q + tram_pkg::IDX_W'(1) : idx_q;
	end

	assign id_ok = (tram_pkg::PEN_TAG == 0)
		|| (lead_d == 8'(tram_pkg::PEN_TAG))
		|| (lead_d == 8'(tram_pkg::ALT_PEN_TAG));

	always_comb begin
		if (id_ok) begin
			rx = {cap_d[2], cap_d[1]};
			ry = {cap_d[5], cap_d[4]};
		end else if (cnt_d >= tram_pkg::IDX_W'(tram_pkg::MIN_SHIFTED_LEN)) begin
			rx = {cap_d[1], cap_d[0]};
			ry = {cap_d[4], cap_d[3]};
		end else begin
			rx = '0;
			ry = '0;
		end
	end

	always_comb begin
		pt.rx   = rx;
		pt.ry   = ry;
		pt.keep = accept && last_byte && (rx != '0 || ry != '0)
			&& rx <= limit_x && ry <= limit_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			lead_q <= '0;
			for (int j = 0; j < tram_pkg::CAP_SLOTS; j++) begin
				cap_q[j] <= '0;
			end
		end else if (accept) begin
			lead_q <= lead_d;
			if (last_byte) begin
				idx_q <= '0;
				for (int j = 0; j < tram_pkg::CAP_SLOTS; j++) begin
					cap_q[j] <= '0;
				end
			end else begin
				idx_q <= cnt_d;
				for (int j = 0; j < tram_pkg::CAP_SLOTS; j++) begin
					cap_q[j] <= cap_d[j];
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tram_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tram_axis (
	input  wire logic                clk,
	input  wire tram_pkg::pipe_ctl_t ctl,
	input  wire logic [15:0]         rx,
	input  wire logic [15:0]         ry,
	input  wire logic signed [31:0]  gain_a,
	input  wire logic signed [31:0]  gain_b,
	input  wire logic signed [47:0]  bias,
	output logic [15:0]              res
);

	logic signed [47:0] prod_a;
	logic signed [47:0] prod_b;
	logic signed [47:0] prod_a_s2;
	logic signed [47:0] prod_b_s2;
	logic signed [49:0] sum;
	logic [15:0]        clamped;
	logic [15:0]        res_s3;

	assign prod_a = 48'(gain_a) * 48'($signed({1'b0, rx}));
	assign prod_b = 48'(gain_b) * 48'($signed({1'b0, ry}));

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
		end
	end

	assign sum = 50'(prod_a_s2) + 50'(prod_b_s2) + 50'(bias);

	// Q34.16 sum: negative gives 0, integer part saturates at 65535
	always_comb begin
		if (sum[49]) begin
			clamped = '0;
		end else if (|sum[48:32]) begin
			clamped = 16'hFFFF;
		end else begin
			clamped = sum[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			res_s3 <= clamped;
		end
	end

	assign res = res_s3;

endmodule

`default_nettype wire

@@ rtl/tablet_report_area_mapper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pen tablet report area mapper.
// Input channel: one report byte per item (report_byte, last_byte) on
// in_valid / in_stall. Bytes may arrive back to back, one item per cycle while in_stall is low.
// Output channel: one absolute point (abs_x, abs_y) on out_valid / out_stall,
// produced only for the last byte of a report whose point is nonzero and in range.
// Pipeline: the extracted and range-checked point is registered at the
// accepting edge, then the four 32x17 multiplies and the sum and clamp
// take one stage each.
// Throughput is one byte per cycle with no gaps between reports while in_stall is low.
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i,
// no wait states; the user writes registers only while no report is in flight (unenforced).
// Reset: the byte count, captured bytes and all valid flags clear, and the
// registers return to their default mapping. Nothing is emitted afterwards
// until a full report has arrived.
// Stall: when out_stall holds a result, bubbles in the pipeline close up
// first; in_stall rises only once all stages are full.
`include "assert_macros.svh"

module tablet_report_area_mapper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  report_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      abs_x,
	output logic [15:0]      abs_y,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	logic [15:0]        limit_x_q;
	logic [15:0]        limit_y_q;
	logic signed [31:0] gain_xx_q;
	logic signed [31:0] gain_xy_q;
	logic signed [31:0] gain_yx_q;
	logic signed [31:0] gain_yy_q;
	logic signed [47:0] bias_x_q;
	logic signed [47:0] bias_y_q;

	logic                cfg_wr;
	tram_pkg::cfg_reg_t  cfg_sel;

	logic                en_s1;
	logic                accept;
	tram_pkg::point_t    pt;
	tram_pkg::pipe_ctl_t ctl;
	logic                v_s1;
	logic                v_s2;
	logic                out_valid_q;
	logic [15:0]         rx_s1;
	logic [15:0]         ry_s1;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = tram_pkg::cfg_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_x_q <= 16'd15200;
			limit_y_q <= 16'd9500;
			gain_xx_q <= 32'sd282559;
			gain_xy_q <= '0;
			gain_yx_q <= '0;
			gain_yy_q <= 32'sd452095;
			bias_x_q  <= '0;
			bias_y_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				tram_pkg::REG_LIMIT_X: limit_x_q <= pwdata[15:0];
				tram_pkg::REG_LIMIT_Y: limit_y_q <= pwdata[15:0];
				tram_pkg::REG_GAIN_XX: gain_xx_q <= $signed(pwdata[31:0]);
				tram_pkg::REG_GAIN_XY: gain_xy_q <= $signed(pwdata[31:0]);
				tram_pkg::REG_GAIN_YX: gain_yx_q <= $signed(pwdata[31:0]);
				tram_pkg::REG_GAIN_YY: gain_yy_q <= $signed(pwdata[31:0]);
				tram_pkg::REG_BIAS_X:  bias_x_q  <= $signed(pwdata[47:0]);
				tram_pkg::REG_BIAS_Y:  bias_y_q  <= $signed(pwdata[47:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			tram_pkg::REG_LIMIT_X: prdata = 64'(limit_x_q);
			tram_pkg::REG_LIMIT_Y: prdata = 64'(limit_y_q);
			tram_pkg::REG_GAIN_XX: prdata = 64'(unsigned'(gain_xx_q));
			tram_pkg::REG_GAIN_XY: prdata = 64'(unsigned'(gain_xy_q));
			tram_pkg::REG_GAIN_YX: prdata = 64'(unsigned'(gain_yx_q));
			tram_pkg::REG_GAIN_YY: prdata = 64'(unsigned'(gain_yy_q));
			tram_pkg::REG_BIAS_X:  prdata = 64'(unsigned'(bias_x_q));
			tram_pkg::REG_BIAS_Y:  prdata = 64'(unsigned'(bias_y_q));
			default:               prdata = '0;
		endcase
	end

	// stage enables: a stage moves when it is empty or the next one moves
	assign ctl.en_s3 = !out_valid_q || !out_stall;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign en_s1     = !v_s1 || ctl.en_s2;
	assign in_stall  = !en_s1;
	assign accept    = in_valid && en_s1;

	tram_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.report_byte (report_byte),
		.last_byte   (last_byte),
		.limit_x     (limit_x_q),
		.limit_y     (limit_y_q),
		.pt          (pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pt.keep;
			end
			if (ctl.en_s2) begin
				v_s2 <= v_s1;
			end
			if (ctl.en_s3) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rx_s1 <= pt.rx;
			ry_s1 <= pt.ry;
		end
	end

	tram_axis u_axis_x (
		.clk    (clk),
		.ctl    (ctl),
		.rx     (rx_s1),
		.ry     (ry_s1),
		.gain_a (gain_xx_q),
		.gain_b (gain_xy_q),
		.bias   (bias_x_q),
		.res    (abs_x)
	);

	tram_axis u_axis_y (
		.clk    (clk),
		.ctl    (ctl),
		.rx     (rx_s1),
		.ry     (ry_s1),
		.gain_a (gain_yx_q),
		.gain_b (gain_yy_q),
		.bias   (bias_y_q),
		.res    (abs_y)
	);

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_pt_nonzero, v_s1 |-> (rx_s1 != 16'd0 || ry_s1 != 16'd0), "zero point passed")
	`ASSERT_CLK(a_pt_in_range, v_s1 |-> (rx_s1 <= limit_x_q && ry_s1 <= limit_y_q), "point out of range passed")
	`ASSERT_CLK(a_no_stall_empty, !out_valid_q |-> !in_stall, "input stalled with empty output")
	`ASSERT_RST(a_reset_quiet, !arst_n |-> (!out_valid_q && !v_s1 && !v_s2), "pipeline busy in reset")

endmodule

`default_nettype wire

@@ verif/tram_checker.sv @@
`timescale 1ns / 1ps

module tram_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  report_byte,
	input  wire logic        last_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [15:0] abs_x,
	input  wire logic [15:0] abs_y,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
	} abs_point_t;

	logic [15:0] lim_x, lim_y;
	logic [31:0] g_xx, g_xy, g_yx, g_yy;
	logic [47:0] b_x, b_y;
	logic [6:0]  byte_cnt;
	logic [7:0]  lead;
	logic [7:0]  cap [tram_pkg::CAP_SLOTS];
	abs_point_t  point_q [$];
	int          fails;

	assign fail_count = fails;

	// q16.16 gains on unsigned raw counts plus q32.16 bias, floored and clamped
	function automatic logic [15:0] affine_axis(input logic [31:0] ga, input logic [31:0] gb,
			input logic [47:0] bias, input logic [15:0] ra, input logic [15:0] rb);
		longint acc;
		acc = longint'($signed(ga)) * longint'(ra) + longint'($signed(gb)) * longint'(rb)
			+ longint'($signed(bias));
		if (acc < 0)
			return 16'h0000;
		if ((acc >>> 16) > 65535)
			return 16'hFFFF;
		return acc[31:16];
	endfunction

	task automatic absorb_byte(input logic [7:0] b, input logic l);
		logic [15:0] rx, ry;
		abs_point_t  p;
		int          k;
		if (byte_cnt < 7'(tram_pkg::MAX_REPORT_BYTES)) begin
			if (byte_cnt == 7'd0)
				lead = b;
			for (k = 0; k < 3; k++) begin
				if (byte_cnt == 7'(tram_pkg::X_BYTE_POS - 1 + k))
					cap[k] = b;
				if (byte_cnt == 7'(tram_pkg::Y_BYTE_POS - 1 + k))
					cap[3 + k] = b;
			end
			byte_cnt++;
		end
		if (l) begin
			rx = 16'h0000;
			ry = 16'h0000;
			if (tram_pkg::PEN_TAG == 0 || lead == 8'(tram_pkg::PEN_TAG)
					|| lead == 8'(tram_pkg::ALT_PEN_TAG)) begin
				rx = {cap[2], cap[1]};
				ry = {cap[5], cap[4]};
			end else if (byte_cnt >= 7'(tram_pkg::MIN_SHIFTED_LEN)) begin
				rx = {cap[1], cap[0]};
				ry = {cap[4], cap[3]};
			end
			byte_cnt = 7'd0;
			for (k = 0; k < tram_pkg::CAP_SLOTS; k++)
				cap[k] = 8'h00;
			if ((rx != 16'h0000 || ry != 16'h0000) && rx <= lim_x && ry <= lim_y) begin
				p.x = affine_axis(g_xx, g_xy, b_x, rx, ry);
				p.y = affine_axis(g_yx, g_yy, b_y, rx, ry);
				point_q = {point_q, p};
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		abs_point_t want;
		if (!arst_n) begin
			lim_x = 16'd15200;
			lim_y = 16'd9500;
			g_xx = 32'd282559;
			g_xy = 32'd0;
			g_yx = 32'd0;
			g_yy = 32'd452095;
			b_x = 48'd0;
			b_y = 48'd0;
			byte_cnt = 7'd0;
			lead = 8'h00;
			for (int k = 0; k < tram_pkg::CAP_SLOTS; k++)
				cap[k] = 8'h00;
			point_q.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (tram_pkg::cfg_reg_t'(paddr[5:3]))
					tram_pkg::REG_LIMIT_X: lim_x = pwdata[15:0];
					tram_pkg::REG_LIMIT_Y: lim_y = pwdata[15:0];
					tram_pkg::REG_GAIN_XX: g_xx = pwdata[31:0];
					tram_pkg::REG_GAIN_XY: g_xy = pwdata[31:0];
					tram_pkg::REG_GAIN_YX: g_yx = pwdata[31:0];
					tram_pkg::REG_GAIN_YY: g_yy = pwdata[31:0];
					tram_pkg::REG_BIAS_X:  b_x = pwdata[47:0];
					tram_pkg::REG_BIAS_Y:  b_y = pwdata[47:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				absorb_byte(report_byte, last_byte);
			if (out_valid && !out_stall) begin
				if (point_q.size() == 0) begin
					$error("point with none expected: abs_x %0d abs_y %0d", abs_x, abs_y);
					fails++;
				end else begin
					want = point_q.pop_front();
					if (abs_x !== want.x) begin
						$error("abs_x mismatch: expected %0d, actual %0d", want.x, abs_x);
						fails++;
					end
					if (abs_y !== want.y) begin
						$error("abs_y mismatch: expected %0d, actual %0d", want.y, abs_y);
						fails++;
					end
				end
			end
			outstanding <= point_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  report_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] abs_x;
	logic [15:0] abs_y;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          fail_count;
	int          outstanding;

	logic [7:0]  rpt [$];
	logic [15:0] cur_lim_x, cur_lim_y;
	bit          calm;
	bit          hold_req;

	tablet_report_area_mapper u_top (.*);

	tram_checker u_chk (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stall, or one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				for (n = 0; n < 300; n++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				hold_req = 1'b0;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 20);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		report_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_report();
		foreach (rpt[i])
			send_byte(rpt[i], i == rpt.size() - 1);
	endtask

	// drain: all points out, then a wait for dropped reports still in flight
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input tram_pkg::cfg_reg_t r, input logic [63:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_mapping(input logic [15:0] lx, input logic [15:0] ly,
			input logic [31:0] gxx, input logic [31:0] gxy, input logic [31:0] gyx,
			input logic [31:0] gyy, input logic [47:0] bx, input logic [47:0] by);
		cfg_write(tram_pkg::REG_LIMIT_X, {48'd0, lx});
		cfg_write(tram_pkg::REG_LIMIT_Y, {48'd0, ly});
		cfg_write(tram_pkg::REG_GAIN_XX, {32'd0, gxx});
		cfg_write(tram_pkg::REG_GAIN_XY, {32'd0, gxy});
		cfg_write(tram_pkg::REG_GAIN_YX, {32'd0, gyx});
		cfg_write(tram_pkg::REG_GAIN_YY, {32'd0, gyy});
		cfg_write(tram_pkg::REG_BIAS_X, {16'd0, bx});
		cfg_write(tram_pkg::REG_BIAS_Y, {16'd0, by});
		cur_lim_x = lx;
		cur_lim_y = ly;
	endtask

	// mostly in range, with the limit itself, one past it and zero mixed in
	function automatic logic [15:0] pick_coord(input logic [15:0] lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return lim;
		if (r < 18)
			return lim + 16'd1;
		if (r < 23)
			return 16'h0000;
		return 16'($urandom_range(lim, 0));
	endfunction

	task automatic build_report(input int kind);
		int          len;
		int          i;
		logic [15:0] px, py;
		logic [7:0]  lead;
		rpt.delete();
		px = pick_coord(cur_lim_x);
		py = pick_coord(cur_lim_y);
		if (kind < 70)
			len = $urandom_range(6, 12);
		else if (kind < 80)
			len = $urandom_range(6, 10);
		else if (kind < 95)
			len = $urandom_range(1, 12);
		else
			len = $urandom_range(tram_pkg::MAX_REPORT_BYTES + 1,
				tram_pkg::MAX_REPORT_BYTES + 16);
		for (i = 0; i < len; i++)
			rpt = {rpt, 8'($urandom_range(0, 255))};
		if (kind < 70 || kind >= 95) begin
			lead = $urandom_range(0, 1) ? 8'(tram_pkg::ALT_PEN_TAG) : 8'(tram_pkg::PEN_TAG);
			rpt[0] = lead;
			rpt[tram_pkg::X_BYTE_POS] = px[7:0];
			rpt[tram_pkg::X_BYTE_POS + 1] = px[15:8];
			rpt[tram_pkg::Y_BYTE_POS] = py[7:0];
			rpt[tram_pkg::Y_BYTE_POS + 1] = py[15:8];
		end else if (kind < 80) begin
			// foreign id: coordinates sit one byte lower
			do
				lead = 8'($urandom_range(0, 255));
			while (lead == 8'(tram_pkg::PEN_TAG) || lead == 8'(tram_pkg::ALT_PEN_TAG));
			rpt[0] = lead;
			rpt[tram_pkg::X_BYTE_POS - 1] = px[7:0];
			rpt[tram_pkg::X_BYTE_POS] = px[15:8];
			rpt[tram_pkg::Y_BYTE_POS - 1] = py[7:0];
			rpt[tram_pkg::Y_BYTE_POS] = py[15:8];
		end
	endtask

	initial begin
		int ph;
		int sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		report_byte = 8'h00;
		last_byte = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 6'd0;
		pwdata = 64'd0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_lim_x = 16'd15200;
		cur_lim_y = 16'd9500;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both coordinates exactly at their default limits
		rpt = '{8'h02, 8'hFF, 8'h60, 8'h3B, 8'h1C, 8'h25};
		send_report();
		// alternate id, short: y bytes never arrive and read as zero
		rpt = '{8'h10, 8'h00, 8'h01, 8'h00};
		send_report();
		// foreign id, shifted read
		rpt = '{8'h80, 8'h34, 8'h12, 8'h78, 8'h06, 8'hFF};
		send_report();
		// foreign id too short: zero point, dropped
		rpt = '{8'h05, 8'h11, 8'h22, 8'h33};
		send_report();
		// single-byte report
		rpt = '{8'h02};
		send_report();
		// x one past its limit
		rpt = '{8'h02, 8'h00, 8'h61, 8'h3B, 8'h01, 8'h00};
		send_report();

		for (ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				1: program_mapping(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
					32'hFFFF_FFFF, 32'h0001_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
				2: program_mapping(16'h0000, 16'hFFFF, 32'h0000_0000, 32'h0001_0000,
					32'h8000_0000, 32'h7FFF_FFFF, 48'd0, 48'hFFFF_FFFF_0000);
				3: program_mapping(16'hFFFF, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0,
					48'h0000_8000_0000, 48'h0000_FFFF_0000);
				4: program_mapping(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
					32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
					32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
					32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
					32'($urandom_range(0, 1 << 19)) - 32'(1 << 18),
					48'(longint'($urandom_range(0, 1 << 17)) - 65536) << 16,
					48'(longint'($urandom_range(0, 1 << 17)) - 65536) << 16);
				5: program_mapping(16'($urandom), 16'($urandom), $urandom, $urandom,
					$urandom, $urandom, {16'($urandom), $urandom}, {16'($urandom), $urandom});
				default: ;
			endcase
			calm = (ph == 1);
			if (ph == 2)
				hold_req = 1'b1;
			sent = 0;
			if (ph == 0) begin
				build_report(99);
				sent += rpt.size();
				send_report();
			end
			while (sent < 65) begin
				build_report($urandom_range(0, 99));
				sent += rpt.size();
				send_report();
			end
		end

		settle();
		repeat (12) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
